[rtl/cls_pkg.sv]
// Shared constants for the Cramer's rule solver: field widths and parameter defaults.
// No dependencies; cramer_linear_solver takes names from here by scoped reference.
package cls_pkg;
   localparam int DEF_MAX_N     = 4;
   localparam int DEF_COEF_BITS = 12;
   localparam int DET_BITS      = 50;
   localparam int QUO_BITS      = 64;
   localparam int FRAC_BITS     = 16;
   localparam int SIZE_BITS     = 3;
   localparam int IDX_BITS      = 2;
   localparam int ACC_BITS      = 64;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 3'd4;
endpackage

[rtl/cramer_linear_solver.sv]
// Cramer's rule solver: coefficient store, Leibniz-sum determinant sequencer,
// bit-serial Q16 divider and result register. Depends on cls_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| req_coefficient, req_end_of_system
//  rsp     | out       | rsp_valid/rsp_stall| unknown_index, dets, quotient, flags
//  csr     | in        | csr_valid/csr_ready| csr_system_size
//
// Loading takes one beat per cycle. The end beat starts the solve: each determinant walks
// all n^n column tuples through one shared 64-bit multiplier; a tuple that is a permutation
// has each row's coefficient read and multiplied in, and the product is added or subtracted
// by inversion parity. Each unknown then passes through the divider and the output state.
// req_stall is high after the end beat until the last result is loaded; a stalled result
// holds in the output register. Reset is synchronous and sets size 4.
module cramer_linear_solver #(
   parameter int MAX_N     = cls_pkg::DEF_MAX_N,
   parameter int COEF_BITS = cls_pkg::DEF_COEF_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COEF_BITS-1:0]         req_coefficient,
   input  logic                                req_end_of_system,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cls_pkg::IDX_BITS-1:0]        rsp_unknown_index,
   output logic signed [cls_pkg::DET_BITS-1:0] rsp_numerator_det,
   output logic signed [cls_pkg::DET_BITS-1:0] rsp_system_det,
   output logic signed [cls_pkg::QUO_BITS-1:0] rsp_quotient_q16,
   output logic                                rsp_singular,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cls_pkg::SIZE_BITS-1:0]       csr_system_size
);
   localparam int DEPTH = MAX_N * (MAX_N + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int SW    = cls_pkg::SIZE_BITS;
   localparam int DB    = cls_pkg::DET_BITS;
   localparam int AB    = cls_pkg::ACC_BITS;
   localparam int QB    = cls_pkg::QUO_BITS;
   localparam int FB    = cls_pkg::FRAC_BITS;
   localparam int VB    = DB + FB;
   localparam int STW   = $clog2(VB + 1);
   localparam int PW    = AB + COEF_BITS;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_PERM = 9'b000000010,
      ST_READ = 9'b000000100,
      ST_MUL  = 9'b000001000,
      ST_ACC  = 9'b000010000,
      ST_NEXT = 9'b000100000,
      ST_DONE = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] size_ff, size_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [COEF_BITS-1:0] mem [DEPTH];
   logic signed [COEF_BITS-1:0] rd_data_ff;
   logic [DW-1:0] dig_ff [MAX_N];
   logic [DW-1:0] dig_in [MAX_N];
   logic [DW-1:0] row_ff, row_in, col_ff, col_in;
   logic pass_num_ff, pass_num_in, par_ff, par_in, neg_ff, neg_in;
   logic [AB-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [DB-1:0] sysdet_ff, sysdet_in, num_ff, num_in;
   logic [VB-1:0] dvd_ff, dvd_in;
   logic [DB-1:0] rem_ff, rem_in;
   logic [STW-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [cls_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic [DB-1:0] onum_ff, onum_in, oden_ff, oden_in;
   logic [QB-1:0] oquo_ff, oquo_in;
   logic osing_ff, osing_in, olast_ff, olast_in;

   logic req_take, rsp_free, wr_en, is_perm, inv_par, last_tuple, carry;
   logic [DW-1:0] dig_inc [MAX_N];
   logic [CW-1:0] cap, addr_full;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] col_sel;
   logic signed [PW-1:0] mul_full;
   logic [DB:0] rem_sh, rem_sub;
   logic [QB-1:0] mag, quo_sat;
   logic [SW-1:0] size_last, csr_clamp;

   function automatic logic [DB-1:0] sysdet_abs(input logic [DB-1:0] v);
      sysdet_abs = v[DB-1] ? (DB'(0) - v) : v;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign size_last = size_ff - SW'(1);
   assign cap       = CW'(size_ff) * (CW'(size_ff) + CW'(1));
   assign wr_en     = req_take && (cnt_ff < cap) && (cnt_ff < CW'(DEPTH));

   // numerator pass swaps the selected column for the right-hand side
   assign col_sel   = (pass_num_ff && dig_ff[row_ff] == col_ff) ? CW'(size_ff) :
                      CW'(dig_ff[row_ff]);
   assign addr_full = CW'(row_ff) * (CW'(size_ff) + CW'(1)) + col_sel;
   assign rd_addr   = addr_full[AW-1:0];
   assign mul_full  = $signed(prod_ff) * rd_data_ff;

   always_comb begin
      if (csr_system_size == SW'(0)) begin
         csr_clamp = SW'(1);
      end else if (csr_system_size > SW'(MAX_N)) begin
         csr_clamp = SW'(MAX_N);
      end else begin
         csr_clamp = csr_system_size;
      end
   end

   // permutation test, inversion parity and base-n tuple increment
   always_comb begin
      is_perm = 1'b1;
      inv_par = 1'b0;
      carry   = 1'b1;
      for (int i = 0; i < MAX_N; i++) begin
         for (int j = i + 1; j < MAX_N; j++) begin
            if (SW'(j) < size_ff) begin
               if (dig_ff[i] == dig_ff[j]) begin
                  is_perm = 1'b0;
               end
               if (dig_ff[i] > dig_ff[j]) begin
                  inv_par = ~inv_par;
               end
            end
         end
      end
      for (int i = 0; i < MAX_N; i++) begin
         dig_inc[i] = dig_ff[i];
         if (SW'(i) < size_ff && carry) begin
            if (SW'(dig_ff[i]) == size_last) begin
               dig_inc[i] = '0;
            end else begin
               dig_inc[i] = dig_ff[i] + DW'(1);
               carry      = 1'b0;
            end
         end
      end
      last_tuple = carry;
   end

   assign rem_sh  = {rem_ff, dvd_ff[VB-1]};
   assign rem_sub = rem_sh - {1'b0, sysdet_abs(sysdet_ff)};

   always_comb begin
      mag = (|dvd_ff[VB-1:QB]) ? {QB{1'b1}} : dvd_ff[QB-1:0];
      if (!neg_ff) begin
         quo_sat = mag[QB-1] ? {1'b0, {(QB-1){1'b1}}} : mag;
      end else if (mag > {1'b1, {(QB-1){1'b0}}}) begin
         quo_sat = {1'b1, {(QB-1){1'b0}}};
      end else begin
         quo_sat = QB'(0) - mag;
      end
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pass_num_in  = pass_num_ff;
      par_in       = par_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sysdet_in    = sysdet_ff;
      num_in       = num_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idx_in       = idx_ff;
      onum_in      = onum_ff;
      oden_in      = oden_ff;
      oquo_in      = oquo_ff;
      osing_in     = osing_ff;
      olast_in     = olast_ff;

      if (csr_valid && csr_ready) begin
         size_in = csr_clamp;
      end

      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (req_take && req_end_of_system) begin
               cnt_in      = '0;
               pass_num_in = 1'b0;
               col_in      = '0;
               acc_in      = '0;
               for (int i = 0; i < MAX_N; i++) begin
                  dig_in[i] = '0;
               end
               state_in = ST_PERM;
            end
         end
         ST_PERM: begin
            if (is_perm) begin
               prod_in  = AB'(1);
               row_in   = '0;
               par_in   = inv_par;
               state_in = ST_READ;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = mul_full[AB-1:0];
            row_in  = row_ff + DW'(1);
            state_in = (SW'(row_ff) == size_last) ? ST_ACC : ST_READ;
         end
         ST_ACC: begin
            acc_in   = par_ff ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            dig_in   = dig_inc;
            state_in = last_tuple ? ST_DONE : ST_PERM;
         end
         ST_DONE: begin
            if (!pass_num_ff) begin
               sysdet_in = acc_ff[DB-1:0];
               if (acc_ff[DB-1:0] == '0) begin
                  state_in = ST_OUT;
               end else begin
                  pass_num_in = 1'b1;
                  acc_in      = '0;
                  state_in    = ST_PERM;
               end
            end else begin
               num_in   = acc_ff[DB-1:0];
               state_in = ST_DIV;
               step_in  = '0;
               rem_in   = '0;
               neg_in   = acc_ff[DB-1] ^ sysdet_ff[DB-1];
               dvd_in   = {(acc_ff[DB-1] ? (DB'(0) - acc_ff[DB-1:0]) : acc_ff[DB-1:0]),
                           FB'(0)};
            end
         end
         ST_DIV: begin
            // restoring step: one quotient bit per cycle
            if (!rem_sub[DB]) begin
               rem_in = rem_sub[DB-1:0];
               dvd_in = {dvd_ff[VB-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DB-1:0];
               dvd_in = {dvd_ff[VB-2:0], 1'b0};
            end
            step_in = step_ff + STW'(1);
            if (step_ff == STW'(VB - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (!pass_num_ff) begin
                  idx_in   = '0;
                  onum_in  = '0;
                  oden_in  = '0;
                  oquo_in  = '0;
                  osing_in = 1'b1;
                  olast_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = cls_pkg::IDX_BITS'(col_ff);
                  onum_in  = num_ff;
                  oden_in  = sysdet_ff;
                  oquo_in  = quo_sat;
                  osing_in = 1'b0;
                  olast_in = (SW'(col_ff) == size_last);
                  if (SW'(col_ff) == size_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     col_in   = col_ff + DW'(1);
                     acc_in   = '0;
                     for (int i = 0; i < MAX_N; i++) begin
                        dig_in[i] = '0;
                     end
                     state_in = ST_PERM;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // coefficient store: write on load beats, registered read for the sequencer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= req_coefficient;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= cls_pkg::SIZE_RESET;
         cnt_ff       <= '0;
         sysdet_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         cnt_ff       <= cnt_in;
         sysdet_ff    <= sysdet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      pass_num_ff <= pass_num_in;
      par_ff      <= par_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      onum_ff     <= onum_in;
      oden_ff     <= oden_in;
      oquo_ff     <= oquo_in;
      osing_ff    <= osing_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unknown_index = idx_ff;
   assign rsp_numerator_det = onum_ff;
   assign rsp_system_det    = oden_ff;
   assign rsp_quotient_q16  = oquo_ff;
   assign rsp_singular      = osing_ff;
   assign rsp_last_result   = olast_ff;
endmodule
